@@ rtl/pcf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_pkg
// Beat types and fixed constants of the plane coincidence finder.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam logic [2:0]  LIGHT_PLANE  = 3'd7;
  localparam int          MAX_RESULTS  = 8;
  localparam logic [15:0] WINDOW_RESET = 16'd240;

  typedef struct packed {
    logic signed [31:0] hit_time_ns;
    logic [2:0]         plane;
    logic [6:0]         light_multiplicity;
    logic               end_of_event;
  } hit_t;

  typedef struct packed {
    logic signed [31:0] start_time_ns;
    logic [7:0]         plane_mask;
    logic               has_light_hit;
    logic [6:0]         multiplicity;
    logic               overflow_seen;
    logic               last_of_run;
  } coinc_t;

endpackage
`default_nettype wire

@@ rtl/plane_coincidence_finder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plane_coincidence_finder
// Buffers trigger hits in a circular memory and judges start hits against
// an inclusive time window, scanning one buffered hit at a time.
//
// Input channel (in_valid/in_ready/in_data): one hit per beat, times
// nondecreasing within an event. in_ready is high only while the sequencer
// is idle; a beat that meets an empty buffer is stored without a scan.
// Output channel (out_valid/out_ready/out_data): zero to eight coincidence
// beats per input beat; last_of_run marks the last one of each run.
// Configuration: cfg_we writes cfg_wdata into the window width.
// Scanning: each start is judged by reading the buffered hits in turn
// through the single registered read port of the hit memory, a fetch state
// and then an evaluate state for each hit; a start that emits also passes
// the emit state. Short windows keep the buffer shallow.
// A found result waits in a holding register and moves to the output
// register when the next one is found or the run ends; while the receiver
// stalls the sequencer waits at that move. Reset empties the buffer, clears
// the drop flag and sets the window to 240 ns; no clearing pass is needed.
// ----------------------------------------------------------------------------
module plane_coincidence_finder #(
  parameter int HIT_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [15:0]    cfg_wdata,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pcf_pkg::hit_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pcf_pkg::coinc_t     out_data
);
  import pcf_pkg::*;

  localparam int AW = $clog2(HIT_DEPTH);
  localparam int CW = $clog2(HIT_DEPTH + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_FETCH  = 4'd2;
  localparam logic [3:0] ST_EVAL   = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_END    = 4'd6;
  localparam logic [3:0] ST_STORE  = 4'd7;
  localparam logic [3:0] ST_FLUSH  = 4'd8;

  typedef struct packed {
    logic signed [31:0] t;
    logic [2:0]         p;
    logic [6:0]         m;
  } entry_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(HIT_DEPTH)) s = s - (AW+1)'(HIT_DEPTH);
    return s[AW-1:0];
  endfunction

  entry_t             mem [HIT_DEPTH];
  entry_t             rdata;
  logic [3:0]         state;
  logic [15:0]        window_ns;
  logic [AW-1:0]      hd;
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      j;
  logic               dropped;
  logic               force_all;
  hit_t               hit;
  logic [3:0]         n_res;
  logic signed [31:0] start_t;
  logic [2:0]         sp;
  logic [7:0]         mask;
  logic               light;
  logic [6:0]         mult;
  logic               other;
  logic               beyond;
  logic signed [33:0] win_end;
  coinc_t             pend;
  logic               pend_v;

  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      wr_idx;
  logic signed [33:0] end_calc;
  logic signed [33:0] end_use;
  logic signed [33:0] rtime_x;
  logic signed [33:0] next_x;
  logic               slot_free;
  logic               out_load;
  logic [CW-1:0]      j_inc;
  logic [CW-1:0]      drop_n;

  assign rd_idx    = wrap_add(hd, j[AW-1:0]);
  assign wr_idx    = wrap_add(hd, cnt[AW-1:0]);
  assign end_calc  = 34'(rdata.t) + $signed({18'b0, window_ns});
  assign end_use   = (j == '0) ? end_calc : win_end;
  assign rtime_x   = 34'(rdata.t);
  assign next_x    = 34'(hit.hit_time_ns);
  assign slot_free = !out_valid || out_ready;
  assign out_load  = pend_v && slot_free && (state == ST_EMIT || state == ST_FLUSH);
  assign j_inc     = j + 1'b1;
  assign drop_n    = other ? j : CW'(1);
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    rdata <= mem[rd_idx];
    if (state == ST_STORE && cnt < CW'(HIT_DEPTH)) begin
      mem[wr_idx] <= '{t: hit.hit_time_ns, p: hit.plane, m: hit.light_multiplicity};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      window_ns <= WINDOW_RESET;
      hd        <= '0;
      cnt       <= '0;
      j         <= '0;
      dropped   <= 1'b0;
      force_all <= 1'b0;
      n_res     <= '0;
      pend_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) window_ns <= cfg_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            hit       <= in_data;
            force_all <= 1'b0;
            n_res     <= '0;
            state     <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          j <= '0;
          if (cnt != '0 && n_res < 4'(MAX_RESULTS)) state <= ST_FETCH;
          else state <= ST_END;
        end
        ST_FETCH: state <= ST_EVAL;
        ST_EVAL: begin
          if (j == '0) begin
            start_t <= rdata.t;
            sp      <= rdata.p;
            mask    <= 8'd1 << rdata.p;
            light   <= (rdata.p == LIGHT_PLANE);
            mult    <= (rdata.p == LIGHT_PLANE) ? rdata.m : 7'd0;
            other   <= 1'b0;
            win_end <= end_calc;
          end else if (rtime_x <= win_end) begin
            mask <= mask | (8'd1 << rdata.p);
            if (rdata.p != sp) begin
              other <= 1'b1;
              if (rdata.p == LIGHT_PLANE) begin
                light <= 1'b1;
                mult  <= rdata.m;
              end
            end
          end
          if (j != '0 && rtime_x > win_end) begin
            beyond <= 1'b1;
            state  <= ST_DECIDE;
          end else begin
            j <= j_inc;
            if (j_inc < cnt) begin
              state <= ST_FETCH;
            end else begin
              beyond <= force_all || (next_x > end_use);
              state  <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (!beyond) state <= ST_END;
          else if (other) state <= ST_EMIT;
          else begin
            if (cnt == CW'(1)) begin
              cnt <= '0;
              hd  <= '0;
            end else begin
              cnt <= cnt - 1'b1;
              hd  <= wrap_add(hd, AW'(1));
            end
            state <= ST_CHECK;
          end
        end
        ST_EMIT: begin
          if (!pend_v || slot_free) begin
            if (pend_v) out_data <= pend;
            pend   <= '{start_time_ns: start_t, plane_mask: mask, has_light_hit: light,
                        multiplicity: mult, overflow_seen: dropped, last_of_run: 1'b0};
            pend_v <= 1'b1;
            n_res  <= n_res + 1'b1;
            if (drop_n >= cnt) begin
              cnt <= '0;
              hd  <= '0;
            end else begin
              cnt <= cnt - drop_n;
              hd  <= wrap_add(hd, drop_n[AW-1:0]);
            end
            state <= ST_CHECK;
          end
        end
        ST_END: begin
          if (force_all) begin
            cnt     <= '0;
            hd      <= '0;
            dropped <= 1'b0;
            state   <= ST_FLUSH;
          end else begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (cnt < CW'(HIT_DEPTH)) cnt <= cnt + 1'b1;
          else dropped <= 1'b1;
          if (hit.end_of_event) begin
            force_all <= 1'b1;
            state     <= ST_CHECK;
          end else begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (slot_free) begin
            out_data <= '{start_time_ns: pend.start_time_ns, plane_mask: pend.plane_mask,
                          has_light_hit: pend.has_light_hit,
                          multiplicity: pend.multiplicity,
                          overflow_seen: pend.overflow_seen, last_of_run: 1'b1};
            pend_v   <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(HIT_DEPTH)) else $error("hit count exceeds buffer depth");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    n_res <= 4'(MAX_RESULTS)) else $error("more results than allowed per beat");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_v) else $error("result still held while accepting a beat");

  a_eoe_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_END && force_all) |=> (cnt == '0 && !dropped))
    else $error("end of event did not empty the buffer");
`endif

endmodule
`default_nettype wire

@@ bench/coincidence_checker.sv @@
// ----------------------------------------------------------------------------
// Coincidence checker
// Watches the hit and coincidence channels of the plane coincidence finder.
// Keeps its own copy of the hit buffer, drop flag and window, predicts the
// coincidence beats each accepted hit causes, and compares every accepted
// output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module coincidence_checker #(
  parameter int DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  logic            in_valid,
  input  logic            in_ready,
  input  pcf_pkg::hit_t   in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  pcf_pkg::coinc_t out_data,
  output int              errors,
  output int              pending,
  output int              matched
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcf_pkg::*;

  logic [15:0] window;
  hit_t        held [DEPTH];
  int          held_count;
  bit          dropped;
  int          step_results;
  coinc_t      expected_coincidences [$];

  function automatic void drop_front(input int n);
    if (n >= held_count) begin
      held_count = 0;
    end else begin
      for (int i = 0; i < held_count - n; i++) held[i] = held[i + n];
      held_count = held_count - n;
    end
  endfunction

  function automatic void judge_starts(input bit has_next, input logic signed [31:0] next_time,
                                       input bit flush);
    logic [2:0] sp;
    longint     stop;
    logic [7:0] mask;
    logic [6:0] mult;
    bit         light;
    bit         other;
    bit         beyond;
    int         j;
    coinc_t     c;
    while (held_count > 0 && step_results < MAX_RESULTS) begin
      sp = held[0].plane;
      stop = longint'($signed(held[0].hit_time_ns)) + longint'(window);
      mask = 8'd1 << sp;
      light = (sp == LIGHT_PLANE);
      mult = light ? held[0].light_multiplicity : 7'd0;
      other = 1'b0;
      j = 1;
      while (j < held_count && longint'($signed(held[j].hit_time_ns)) <= stop) begin
        mask = mask | (8'd1 << held[j].plane);
        if (held[j].plane != sp) begin
          other = 1'b1;
          if (held[j].plane == LIGHT_PLANE) begin
            light = 1'b1;
            mult = held[j].light_multiplicity;
          end
        end
        j++;
      end
      beyond = (j < held_count) || (has_next && longint'($signed(next_time)) > stop) || flush;
      if (!beyond) return;
      if (other) begin
        c.start_time_ns = held[0].hit_time_ns;
        c.plane_mask = mask;
        c.has_light_hit = light;
        c.multiplicity = mult;
        c.overflow_seen = dropped;
        c.last_of_run = 1'b0;
        expected_coincidences = {expected_coincidences, c};
        step_results++;
        drop_front(j);
      end else begin
        drop_front(1);
      end
    end
  endfunction

  function automatic void accept_hit(input hit_t h);
    step_results = 0;
    judge_starts(1'b1, h.hit_time_ns, 1'b0);
    if (held_count < DEPTH) begin
      held[held_count] = h;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (h.end_of_event) begin
      judge_starts(1'b0, '0, 1'b1);
      held_count = 0;
      dropped = 1'b0;
    end
    if (step_results > 0)
      expected_coincidences[expected_coincidences.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    coinc_t want;
    if (rst) begin
      window = WINDOW_RESET;
      held_count = 0;
      dropped = 1'b0;
      expected_coincidences.delete();
      errors = 0;
      matched = 0;
    end else begin
      if (cfg_we) window = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_coincidences.size() == 0) begin
          $error("unexpected coincidence beat: start_time_ns %0d, plane_mask %0h",
                 $signed(out_data.start_time_ns), out_data.plane_mask);
          errors++;
        end else begin
          want = expected_coincidences.pop_front();
          check_field("start_time_ns", $signed(want.start_time_ns),
                      $signed(out_data.start_time_ns));
          check_field("plane_mask", want.plane_mask, out_data.plane_mask);
          check_field("has_light_hit", want.has_light_hit, out_data.has_light_hit);
          check_field("multiplicity", want.multiplicity, out_data.multiplicity);
          check_field("overflow_seen", want.overflow_seen, out_data.overflow_seen);
          check_field("last_of_run", want.last_of_run, out_data.last_of_run);
          matched++;
        end
      end
      if (in_valid && in_ready) accept_hit(in_data);
    end
    pending = expected_coincidences.size();
  end

endmodule

@@ bench/plane_coincidence_finder_tb.sv @@
// ----------------------------------------------------------------------------
// Plane coincidence finder testbench
// Drives trigger hits into the finder under random sender and receiver gaps,
// one long receiver hold-off, and several window settings from 0 to 65535.
// Directed events cover time extremes, light-detector multiplicity choice,
// out-of-order times, a full buffer with dropped hits and an eight-beat burst;
// random events follow. The checker module predicts and compares the beats.
// ----------------------------------------------------------------------------
module plane_coincidence_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcf_pkg::*;

  localparam int DEPTH          = 16;
  localparam int SETTLE_CYCLES  = 400;
  localparam int HOLD_CYCLES    = 800;
  localparam int STALL_LIMIT    = 5000;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  hit_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  coinc_t      out_data;

  int          errors;
  int          pending;
  int          matched;
  int          hits_sent = 0;
  int          settings_used = 0;
  int          quiet_cycles = 0;
  logic [15:0] win = WINDOW_RESET;
  bit          hold_armed = 1'b0;
  bit          hold_done = 1'b0;

  always #5 clk = ~clk;

  plane_coincidence_finder #(.HIT_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  coincidence_checker #(.DEPTH(DEPTH)) chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending), .matched(matched)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic hit_t make_hit(input logic signed [31:0] t, input logic [2:0] p,
                                    input logic [6:0] m, input logic eoe);
    hit_t h;
    h.hit_time_ns = t;
    h.plane = p;
    h.light_multiplicity = m;
    h.end_of_event = eoe;
    return h;
  endfunction

  task automatic send_hit(input hit_t h);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= h;
    do @(posedge clk); while (!in_ready);
    hits_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_ready) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    win = value;
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_event(input int len, input bit closed);
    logic signed [31:0] t;
    logic [2:0]         home;
    logic [2:0]         p;
    int                 r;
    r = $urandom_range(0, 9);
    if (r == 0) t = T_MAX - $urandom_range(0, 3000);
    else if (r == 1) t = T_MIN + $urandom_range(0, 3000);
    else if (r == 2) t = $urandom();
    else t = $urandom_range(0, 200000) - 100000;
    home = 3'($urandom_range(0, 7));
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        r = $urandom_range(0, 99);
        if (r < 30) t = t;
        else if (r < 60) t = t + $urandom_range(0, win / 2 + 1);
        else if (r < 75) t = t + win + $urandom_range(0, 1);
        else if (r < 92) t = t + $urandom_range(0, 3 * win + 5);
        else t = $urandom();
      end
      p = $urandom_range(0, 1) ? home : 3'($urandom_range(0, 7));
      send_hit(make_hit(t, p, 7'($urandom_range(0, 127)), closed && k == len - 1));
    end
  endtask

  task automatic run_random_phase(input int n_hits);
    int sent;
    int len;
    int r;
    sent = 0;
    while (sent < n_hits) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 14);
      else len = $urandom_range(17, 20);
      send_event(len, $urandom_range(0, 9) != 0);
      sent += len;
    end
  endtask

  initial begin : receiver
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic signed [31:0] t0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window, earliest time, light-detector start keeps its own multiplicity
    send_hit(make_hit(T_MIN, LIGHT_PLANE, 7'd127, 1'b0));
    send_hit(make_hit(T_MIN + 100, LIGHT_PLANE, 7'd1, 1'b0));
    send_hit(make_hit(T_MIN + 240, 3'd3, 7'h55, 1'b0));
    send_hit(make_hit(T_MIN + 241, 3'd0, 7'd0, 1'b1));
    // window end past the largest time
    send_hit(make_hit(T_MAX - 10, 3'd6, 7'd0, 1'b0));
    send_hit(make_hit(T_MAX, LIGHT_PLANE, 7'd42, 1'b1));
    // descending times
    send_hit(make_hit(32'sd1000, 3'd1, 7'd0, 1'b0));
    send_hit(make_hit(32'sd800, 3'd0, 7'h2a, 1'b0));
    send_hit(make_hit(32'sd700, LIGHT_PLANE, 7'd3, 1'b1));

    // fill past capacity under the widest window, then shrink it for a full burst
    write_window(16'hffff);
    t0 = -32'sd5000;
    for (int k = 0; k < 8; k++) begin
      if (k < 7) begin
        send_hit(make_hit(t0 + 10 * k, 3'(k), 7'($urandom_range(0, 127)), 1'b0));
        send_hit(make_hit(t0 + 10 * k, LIGHT_PLANE, 7'(18 * k), 1'b0));
      end else begin
        send_hit(make_hit(t0 + 10 * k, LIGHT_PLANE, 7'd127, 1'b0));
        send_hit(make_hit(t0 + 10 * k, 3'd0, 7'd5, 1'b0));
      end
    end
    send_hit(make_hit(t0 + 80, 3'd3, 7'd0, 1'b0));
    write_window(16'd0);
    send_hit(make_hit(t0 + 1000, 3'd5, 7'd0, 1'b1));

    write_window(WINDOW_RESET);
    hold_armed = 1'b1;
    run_random_phase(20);
    write_window(16'($urandom_range(1, 400)));
    run_random_phase(20);
    write_window(16'hffff);
    run_random_phase(20);
    write_window(16'd0);
    run_random_phase(20);
    write_window(16'($urandom_range(400, 3000)));
    run_random_phase(20);

    settle();
    $display("Sent %0d hits over %0d window settings; %0d coincidence beats compared.",
             hits_sent, settings_used, matched);
    $display("Receiver held off once for %0d cycles while hits kept coming.", HOLD_CYCLES);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
